// ----- design/radix30_36_number_formatter_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the radix 30/36 number formatter
// Shared concurrent-assertion forms, clocked on clk_i with reset on rst_ni.
// ----------------------------------------------------------------------------
`ifndef RADIX30_36_NUMBER_FORMATTER_DEFINES_SVH
`define RADIX30_36_NUMBER_FORMATTER_DEFINES_SVH

// Same-cycle implication
`define R36FMT_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define R36FMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/r36fmt_pkg.sv -----
// ----------------------------------------------------------------------------
// r36fmt_pkg
// Types, constants and helpers shared by the radix 30/36 formatter modules.
// ----------------------------------------------------------------------------
package r36fmt_pkg;

  // Number and digit sizing
  localparam int VALUE_BITS  = 64;
  localparam int MAX_DIGITS  = 14;
  localparam int CHUNK_W     = 16;
  localparam int NUM_CHUNKS  = (VALUE_BITS + CHUNK_W - 1) / CHUNK_W;
  localparam int WORK_W      = NUM_CHUNKS * CHUNK_W;
  localparam int CHUNK_IDX_W = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W       = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  // Radix constants
  localparam int BASE_30_INT = 30;
  localparam int BASE_36_INT = 36;
  localparam int DIGIT_W     = $clog2(BASE_36_INT);
  localparam int BASE_W      = $clog2(BASE_36_INT + 1);
  localparam logic [BASE_W-1:0] BASE_30 = BASE_W'(BASE_30_INT);
  localparam logic [BASE_W-1:0] BASE_36 = BASE_W'(BASE_36_INT);

  // Long-division step: {remainder, chunk} divided by the radix through a
  // reciprocal multiply and one correction.
  localparam int DIV_X_W     = DIGIT_W + CHUNK_W;
  localparam int RECIP_SHIFT = DIV_X_W;
  localparam int RECIP_W     = $clog2((1 << RECIP_SHIFT) / BASE_30_INT + 1);
  localparam int PROD_W      = DIV_X_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_30 = RECIP_W'((1 << RECIP_SHIFT) / BASE_30_INT);
  localparam logic [RECIP_W-1:0] RECIP_36 = RECIP_W'((1 << RECIP_SHIFT) / BASE_36_INT);

  // Characters
  localparam int CHAR_W = 7;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_A     = CHAR_W'(65);
  localparam logic [CHAR_W-1:0] CHAR_SPACE = CHAR_W'(32);
  localparam int DEC_DIGITS = 10;

  // Digit queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int NUM_REGS  = 1;
  localparam int ADDR_W    = $clog2(NUM_REGS * 4) + 1;
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam int DATA_W    = 32;
  localparam logic [REG_IDX_W-1:0] REG_RADIX_SELECT = REG_IDX_W'(0);
  localparam logic RADIX_SEL_30 = 1'b0;
  localparam logic RADIX_SEL_36 = 1'b1;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_SUB,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SPACE,
    B_DIGIT
  } back_state_e;

  // One converted number: digits least significant first, plus digit count
  typedef struct packed {
    logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits;
    logic [CNT_W-1:0]                   count;
  } digit_entry_t;

  // Digit value to ASCII: 0-9 then A onward
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ch;
    if (d < DIGIT_W'(DEC_DIGITS)) begin
      ch = CHAR_ZERO + CHAR_W'(d);
    end else begin
      ch = CHAR_A + CHAR_W'(d) - CHAR_W'(DEC_DIGITS);
    end
    return ch;
  endfunction

endpackage

// ----- design/r36fmt_queue.sv -----
// ----------------------------------------------------------------------------
// r36fmt_queue
// Short register FIFO of converted numbers between the front and the back.
// ----------------------------------------------------------------------------
module r36fmt_queue (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  r36fmt_pkg::digit_entry_t wdata_i,
  output logic                     full_o,
  input  logic                     pop_i,
  output r36fmt_pkg::digit_entry_t rdata_o,
  output logic                     empty_o
);

  r36fmt_pkg::digit_entry_t [r36fmt_pkg::QUEUE_DEPTH-1:0] entries_q;
  logic [r36fmt_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [r36fmt_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [r36fmt_pkg::QCNT_W-1:0] cnt_q, cnt_d;
  logic                          do_push;
  logic                          do_pop;

  assign full_o  = (cnt_q == r36fmt_pkg::QCNT_W'(r36fmt_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = entries_q[rd_ptr_q];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      if (wr_ptr_q == r36fmt_pkg::QPTR_W'(r36fmt_pkg::QUEUE_DEPTH - 1)) begin
        wr_ptr_d = '0;
      end else begin
        wr_ptr_d = wr_ptr_q + 1'b1;
      end
    end
    if (do_pop) begin
      if (rd_ptr_q == r36fmt_pkg::QPTR_W'(r36fmt_pkg::QUEUE_DEPTH - 1)) begin
        rd_ptr_d = '0;
      end else begin
        rd_ptr_d = rd_ptr_q + 1'b1;
      end
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- design/r36fmt_front.sv -----
// ----------------------------------------------------------------------------
// r36fmt_front
// Accepts a number and splits it into radix digits by repeated long division,
// one 16-bit chunk per multiply and correct step, then queues the digit set.
// ----------------------------------------------------------------------------
module r36fmt_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     radix_sel_i,
  input  logic                     push_i,
  input  logic [63:0]              value_i,
  output logic                     full_o,
  output logic                     q_push_o,
  output r36fmt_pkg::digit_entry_t q_entry_o,
  input  logic                     q_full_i
);

  r36fmt_pkg::front_state_e state_q, state_d;

  logic [r36fmt_pkg::NUM_CHUNKS-1:0][r36fmt_pkg::CHUNK_W-1:0] val_q, val_d, val_nx;
  logic [r36fmt_pkg::DIGIT_W-1:0]     rem_q, rem_d;
  logic [r36fmt_pkg::CHUNK_IDX_W-1:0] cidx_q, cidx_d;
  logic [r36fmt_pkg::PROD_W-1:0]      prod_q, prod_d;
  logic [r36fmt_pkg::MAX_DIGITS-1:0][r36fmt_pkg::DIGIT_W-1:0] digits_q, digits_d;
  logic [r36fmt_pkg::CNT_W-1:0]       ndig_q, ndig_d;

  logic                               load;
  logic                               mul_en;
  logic                               sub_en;
  logic                               num_done;
  logic [r36fmt_pkg::DIV_X_W-1:0]     div_x;
  logic [r36fmt_pkg::RECIP_W-1:0]     recip;
  logic [r36fmt_pkg::BASE_W-1:0]      base;
  logic [r36fmt_pkg::CHUNK_W-1:0]     q_est;
  logic [r36fmt_pkg::DIV_X_W-1:0]     q_times_b;
  logic [r36fmt_pkg::DIV_X_W-1:0]     part_rem;
  logic                               over;
  logic [r36fmt_pkg::CHUNK_W-1:0]     q_new;
  logic [r36fmt_pkg::DIGIT_W-1:0]     rem_new;

  // Divider step: dividend is the running remainder over the current chunk
  assign div_x = {rem_q, val_q[cidx_q]};
  assign recip = (radix_sel_i == r36fmt_pkg::RADIX_SEL_36) ? r36fmt_pkg::RECIP_36
                                                           : r36fmt_pkg::RECIP_30;
  assign base  = (radix_sel_i == r36fmt_pkg::RADIX_SEL_36) ? r36fmt_pkg::BASE_36
                                                           : r36fmt_pkg::BASE_30;

  // Estimate is exact or one low; one compare-subtract fixes it
  assign q_est     = prod_q[r36fmt_pkg::RECIP_SHIFT +: r36fmt_pkg::CHUNK_W];
  assign q_times_b = r36fmt_pkg::DIV_X_W'(q_est) * r36fmt_pkg::DIV_X_W'(base);
  assign part_rem  = div_x - q_times_b;
  assign over      = (part_rem >= r36fmt_pkg::DIV_X_W'(base));
  assign q_new     = over ? (q_est + 1'b1) : q_est;
  assign rem_new   = over ? r36fmt_pkg::DIGIT_W'(part_rem - r36fmt_pkg::DIV_X_W'(base))
                          : r36fmt_pkg::DIGIT_W'(part_rem);

  // Quotient with the current chunk replaced
  always_comb begin
    val_nx         = val_q;
    val_nx[cidx_q] = q_new;
  end

  // Number finished when the quotient reaches zero or the digit buffer fills
  assign num_done = sub_en && (cidx_q == '0) &&
                    ((val_nx == '0) ||
                     (ndig_q == r36fmt_pkg::CNT_W'(r36fmt_pkg::MAX_DIGITS - 1)));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      r36fmt_pkg::F_IDLE: begin
        if (push_i) begin
          state_d = r36fmt_pkg::F_MUL;
        end
      end
      r36fmt_pkg::F_MUL: begin
        state_d = r36fmt_pkg::F_SUB;
      end
      r36fmt_pkg::F_SUB: begin
        if (num_done) begin
          state_d = r36fmt_pkg::F_PUSH;
        end else begin
          state_d = r36fmt_pkg::F_MUL;
        end
      end
      r36fmt_pkg::F_PUSH: begin
        if (!q_full_i) begin
          state_d = r36fmt_pkg::F_IDLE;
        end
      end
      default: begin
        state_d = r36fmt_pkg::F_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    full_o   = 1'b1;
    load     = 1'b0;
    mul_en   = 1'b0;
    sub_en   = 1'b0;
    q_push_o = 1'b0;
    case (state_q)
      r36fmt_pkg::F_IDLE: begin
        full_o = 1'b0;
        load   = push_i;
      end
      r36fmt_pkg::F_MUL: begin
        mul_en = 1'b1;
      end
      r36fmt_pkg::F_SUB: begin
        sub_en = 1'b1;
      end
      r36fmt_pkg::F_PUSH: begin
        q_push_o = !q_full_i;
      end
      default: begin
        full_o = 1'b1;
      end
    endcase
  end

  assign q_entry_o.digits = digits_q;
  assign q_entry_o.count  = ndig_q;

  // Datapath next values
  always_comb begin
    val_d    = val_q;
    rem_d    = rem_q;
    cidx_d   = cidx_q;
    prod_d   = prod_q;
    digits_d = digits_q;
    ndig_d   = ndig_q;
    if (load) begin
      val_d  = r36fmt_pkg::WORK_W'(value_i[r36fmt_pkg::VALUE_BITS-1:0]);
      rem_d  = '0;
      cidx_d = r36fmt_pkg::CHUNK_IDX_W'(r36fmt_pkg::NUM_CHUNKS - 1);
      ndig_d = '0;
    end
    if (mul_en) begin
      prod_d = r36fmt_pkg::PROD_W'(div_x) * r36fmt_pkg::PROD_W'(recip);
    end
    if (sub_en) begin
      val_d = val_nx;
      if (cidx_q == '0) begin
        // last chunk: remainder is the next digit, restart from the top
        digits_d[ndig_q[r36fmt_pkg::IDX_W-1:0]] = rem_new;
        ndig_d = ndig_q + 1'b1;
        rem_d  = '0;
        cidx_d = r36fmt_pkg::CHUNK_IDX_W'(r36fmt_pkg::NUM_CHUNKS - 1);
      end else begin
        rem_d  = rem_new;
        cidx_d = cidx_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= r36fmt_pkg::F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    rem_q    <= rem_d;
    cidx_q   <= cidx_d;
    prod_q   <= prod_d;
    digits_q <= digits_d;
    ndig_q   <= ndig_d;
  end

endmodule

// ----- design/r36fmt_back.sv -----
// ----------------------------------------------------------------------------
// r36fmt_back
// Takes converted numbers from the queue and emits their ASCII characters,
// most significant digit first, through a one-entry output register.
// ----------------------------------------------------------------------------
module r36fmt_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_empty_i,
  input  r36fmt_pkg::digit_entry_t         q_entry_i,
  output logic                             q_pop_o,
  output logic                             busy_o,
  output logic                             empty_o,
  input  logic                             pop_i,
  output logic [r36fmt_pkg::CHAR_W-1:0]    ascii_char_o,
  output logic                             last_char_o
);

  r36fmt_pkg::back_state_e state_q, state_d;

  logic [r36fmt_pkg::IDX_W-1:0]  idx_q, idx_d;
  logic                          out_valid_q, out_valid_d;
  logic [r36fmt_pkg::CHAR_W-1:0] char_q, char_d;
  logic                          last_q, last_d;

  logic                          slot_free;
  logic                          load;
  logic                          emit;
  logic                          emit_space;
  logic                          emit_last;

  // Output register can take a character when empty or being drained
  assign slot_free = !out_valid_q || pop_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      r36fmt_pkg::B_IDLE: begin
        if (!q_empty_i) begin
          if (q_entry_i.count == r36fmt_pkg::CNT_W'(1)) begin
            state_d = r36fmt_pkg::B_SPACE;
          end else begin
            state_d = r36fmt_pkg::B_DIGIT;
          end
        end
      end
      r36fmt_pkg::B_SPACE: begin
        if (slot_free) begin
          state_d = r36fmt_pkg::B_DIGIT;
        end
      end
      r36fmt_pkg::B_DIGIT: begin
        if (slot_free && (idx_q == '0)) begin
          state_d = r36fmt_pkg::B_IDLE;
        end
      end
      default: begin
        state_d = r36fmt_pkg::B_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    load       = 1'b0;
    emit       = 1'b0;
    emit_space = 1'b0;
    emit_last  = 1'b0;
    q_pop_o    = 1'b0;
    case (state_q)
      r36fmt_pkg::B_IDLE: begin
        load = !q_empty_i;
      end
      r36fmt_pkg::B_SPACE: begin
        emit       = slot_free;
        emit_space = 1'b1;
      end
      r36fmt_pkg::B_DIGIT: begin
        emit      = slot_free;
        emit_last = (idx_q == '0);
        q_pop_o   = slot_free && (idx_q == '0);
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  assign busy_o = (state_q inside {r36fmt_pkg::B_SPACE, r36fmt_pkg::B_DIGIT});

  // Digit walk and output register
  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    if (load) begin
      idx_d = r36fmt_pkg::IDX_W'(q_entry_i.count - 1'b1);
    end
    if (pop_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      last_d      = emit_last;
      if (emit_space) begin
        char_d = r36fmt_pkg::CHAR_SPACE;
      end else begin
        char_d = r36fmt_pkg::digit_char(q_entry_i.digits[idx_q]);
        if (idx_q != '0) begin
          idx_d = idx_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= r36fmt_pkg::B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign empty_o      = !out_valid_q;
  assign ascii_char_o = char_q;
  assign last_char_o  = last_q;

endmodule

// ----- design/radix30_36_number_formatter.sv -----
// ----------------------------------------------------------------------------
// radix30_36_number_formatter
// Formats unsigned 64-bit numbers as base-30 or base-36 ASCII, MSD first.
// ----------------------------------------------------------------------------
// A number is pushed in and comes out as a string of characters, one result
// transaction per character, most significant digit first, with last_char_o
// set on the final one; a one-digit number (zero included) is preceded by a
// space. Digits are produced by long division of the number by the radix,
// 16 bits at a time through one reciprocal multiplier and a correction step:
// each digit takes a multiply, then a correct step, for each of four chunks,
// up to 14 digits per number, in the front end. A two-entry queue lets the
// next number be converted while the previous one is still being read out
// at up to one character per cycle, as long as pop keeps the output drained.
// radix_select (address 0x0, bit 0, reset 1) picks base 36 when set and base
// 30 when clear; change it only while idle.
// ----------------------------------------------------------------------------
`include "radix30_36_number_formatter_defines.svh"

module radix30_36_number_formatter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // APB configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [r36fmt_pkg::ADDR_W-1:0]     paddr,
  input  logic [r36fmt_pkg::DATA_W-1:0]     pwdata,
  output logic [r36fmt_pkg::DATA_W-1:0]     prdata,
  output logic                              pready,
  // Number input
  input  logic                              push,
  output logic                              full,
  input  logic [63:0]                       value_i,
  // Character output
  output logic                              empty,
  input  logic                              pop,
  output logic [r36fmt_pkg::CHAR_W-1:0]     ascii_char_o,
  output logic                              last_char_o
);

  logic                     radix_q, radix_d;
  logic                     cfg_wr;
  logic [r36fmt_pkg::REG_IDX_W-1:0] reg_idx;

  logic                     q_push;
  logic                     q_full;
  logic                     q_pop;
  logic                     q_empty;
  logic                     back_busy;
  r36fmt_pkg::digit_entry_t q_wdata;
  r36fmt_pkg::digit_entry_t q_rdata;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_idx = paddr[r36fmt_pkg::ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready &&
                   (reg_idx == r36fmt_pkg::REG_RADIX_SELECT);

  always_comb begin
    radix_d = radix_q;
    if (cfg_wr) begin
      radix_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= r36fmt_pkg::RADIX_SEL_36;
    end else begin
      radix_q <= radix_d;
    end
  end

  assign prdata = (reg_idx == r36fmt_pkg::REG_RADIX_SELECT) ?
                  r36fmt_pkg::DATA_W'(radix_q) : '0;

  // Digit extraction
  r36fmt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .radix_sel_i (radix_q),
    .push_i      (push),
    .value_i     (value_i),
    .full_o      (full),
    .q_push_o    (q_push),
    .q_entry_o   (q_wdata),
    .q_full_i    (q_full)
  );

  // Decoupling queue
  r36fmt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  // Character emission
  r36fmt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_entry_i    (q_rdata),
    .q_pop_o      (q_pop),
    .busy_o       (back_busy),
    .empty_o      (empty),
    .pop_i        (pop),
    .ascii_char_o (ascii_char_o),
    .last_char_o  (last_char_o)
  );

  // Assertions
  `R36FMT_ASSERT_IMPLIES(a_back_has_entry, back_busy, !q_empty, "back end busy with no queued number")
  `R36FMT_ASSERT_IMPLIES(a_space_not_last, !empty && (ascii_char_o == r36fmt_pkg::CHAR_SPACE), !last_char_o, "space marked as last character")
  `R36FMT_ASSERT_NEXT(a_accept_blocks, push && !full, full, "front end took a number but stays open")

endmodule
